// ===== src/wtw_pkg.sv =====
// Shared types, constants and helper functions of the weekly time window table.
package wtw_pkg;

  // Calendar limits.
  localparam int Days       = 7;
  localparam int MinPerHour = 60;
  localparam int MaxHour    = 23;
  localparam int MaxMinute  = 59;

  // Width of a minute-of-day value (0..1439).
  localparam int MinW = 11;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_CHECK = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_DAY  = 2'd1,
    FAULT_FULL = 2'd2,
    FAULT_TIME = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_e;

  // Input word.
  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] day;
    logic [4:0] start_hour;
    logic [5:0] start_minute;
    logic [4:0] end_hour;
    logic [5:0] end_minute;
    logic [4:0] query_hour;
    logic [5:0] query_minute;
  } req_t;

  // Result word.
  typedef struct packed {
    logic   success;
    fault_e fault;
  } res_t;

  // One stored window, kept as minute-of-day bounds.
  typedef struct packed {
    logic [MinW-1:0] start_min;
    logic [MinW-1:0] end_min;
  } win_t;

  // Commands to the fill count table.
  typedef struct packed {
    logic clr;
    logic inc;
  } fill_cmd_t;

  function automatic logic time_ok(logic [4:0] h, logic [5:0] m);
    return (h <= 5'(MaxHour)) && (m <= 6'(MaxMinute));
  endfunction

  function automatic logic [MinW-1:0] minute_of_day(logic [4:0] h, logic [5:0] m);
    return MinW'(h) * MinW'(MinPerHour) + MinW'(m);
  endfunction

endpackage

// ===== src/wtw_mem.sv =====
// Window memory: one write port, one read port with registered read data.
module wtw_mem #(
  parameter int Depth = 56,
  parameter int AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  wtw_pkg::win_t       wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output wtw_pkg::win_t       rdata_o
);

  wtw_pkg::win_t mem_q [Depth];
  wtw_pkg::win_t rdata_q;

  // Synchronous write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/wtw_fill.sv =====
// Per-day fill counts with a clear of all days and an increment of one day.
module wtw_fill #(
  parameter int CntW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wtw_pkg::fill_cmd_t   cmd_i,
  input  logic [2:0]           day_i,
  output logic [CntW-1:0]      count_o
);

  logic [CntW-1:0] cnt_q [wtw_pkg::Days];

  // Clear zeroes every day; increment bumps the selected day.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wtw_pkg::Days; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < wtw_pkg::Days; i++) begin
        if (cmd_i.clr) begin
          cnt_q[i] <= '0;
        end else if (cmd_i.inc && (day_i == 3'(i))) begin
          cnt_q[i] <= cnt_q[i] + CntW'(1);
        end
      end
    end
  end

  // Count of the selected day; an invalid day reads as empty.
  always_comb begin
    count_o = '0;
    if (day_i < 3'(wtw_pkg::Days)) begin
      count_o = cnt_q[day_i];
    end
  end

endmodule

// ===== src/weekly_time_window_table.sv =====
// Top level of the weekly time window table: control sequencer and result register.
//
//  Channel  Ports                      Handshake
//  -------  -------------------------  ------------------------------------------
//  input    start_i, busy_o, req_i     word taken at an edge with start_i && !busy_o
//  output   done_o, res_o              word valid for one cycle while done_o is high
//
// Clear, add, a fault and an unused mode pass the EXEC state and then the done register
// on the way to the done strobe. A check with stored windows also walks them in ST_SCAN
// (at most SLOTS), one read per cycle over the window memory, and stops at a hit.
// Reset clears the fill counts at once; the window memory needs no clearing.
// busy_o is high from acceptance until the done strobe; the receiver cannot stall.
module weekly_time_window_table #(
  parameter int SLOTS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  wtw_pkg::req_t   req_i,
  output logic            busy_o,
  output logic            done_o,
  output wtw_pkg::res_t   res_o
);

  localparam int Depth = wtw_pkg::Days * SLOTS;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CntW  = $clog2(SLOTS + 1);

  wtw_pkg::state_e state_q, state_d;
  wtw_pkg::req_t   req_q;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            done_q, done_d;
  wtw_pkg::res_t   res_q, res_d;

  wtw_pkg::fill_cmd_t fill_cmd;
  logic [CntW-1:0]    count;

  logic               mem_we;
  logic               mem_re;
  logic [IdxW-1:0]    rd_idx_addr;
  logic [AddrW-1:0]   mem_waddr;
  logic [AddrW-1:0]   mem_raddr;
  wtw_pkg::win_t      mem_wdata;
  wtw_pkg::win_t      mem_rdata;

  logic [wtw_pkg::MinW-1:0] start_min;
  logic [wtw_pkg::MinW-1:0] end_min;
  logic [wtw_pkg::MinW-1:0] query_min;
  logic                     day_ok;
  logic                     add_time_ok;
  logic                     hit;
  logic [CntW-1:0]          next_idx;

  wtw_fill #(
    .CntW (CntW)
  ) u_fill (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (fill_cmd),
    .day_i   (req_q.day),
    .count_o (count)
  );

  wtw_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Minute-of-day values and validity of the held word.
  assign start_min   = wtw_pkg::minute_of_day(req_q.start_hour, req_q.start_minute);
  assign end_min     = wtw_pkg::minute_of_day(req_q.end_hour, req_q.end_minute);
  assign query_min   = wtw_pkg::minute_of_day(req_q.query_hour, req_q.query_minute);
  assign day_ok      = req_q.day < 3'(wtw_pkg::Days);
  assign add_time_ok = wtw_pkg::time_ok(req_q.start_hour, req_q.start_minute) &&
                       wtw_pkg::time_ok(req_q.end_hour, req_q.end_minute) &&
                       (start_min < end_min);

  // Window at the head of the read pipe contains the query time.
  assign hit      = (mem_rdata.start_min <= query_min) && (query_min <= mem_rdata.end_min);
  assign next_idx = CntW'(rd_idx_q) + CntW'(1);

  // Memory addresses: day-major rows of SLOTS entries.
  assign mem_wdata = '{start_min: start_min, end_min: end_min};
  assign mem_waddr = AddrW'(req_q.day) * AddrW'(SLOTS) + AddrW'(count);
  assign mem_raddr = AddrW'(req_q.day) * AddrW'(SLOTS) + AddrW'(rd_idx_addr);

  // Next state, memory access and result.
  always_comb begin
    state_d     = state_q;
    rd_idx_d    = rd_idx_q;
    rd_idx_addr = rd_idx_q;
    done_d      = 1'b0;
    res_d       = '{success: 1'b0, fault: wtw_pkg::FAULT_NONE};
    fill_cmd    = '{clr: 1'b0, inc: 1'b0};
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    case (state_q)
      wtw_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = wtw_pkg::ST_EXEC;
        end
      end

      wtw_pkg::ST_EXEC: begin
        state_d = wtw_pkg::ST_IDLE;
        done_d  = 1'b1;
        if (req_q.mode == wtw_pkg::MODE_CLEAR) begin
          fill_cmd.clr  = 1'b1;
          res_d.success = 1'b1;
        end else if (req_q.mode == wtw_pkg::MODE_ADD) begin
          if (!day_ok) begin
            res_d.fault = wtw_pkg::FAULT_DAY;
          end else if (count >= CntW'(SLOTS)) begin
            res_d.fault = wtw_pkg::FAULT_FULL;
          end else if (!add_time_ok) begin
            res_d.fault = wtw_pkg::FAULT_TIME;
          end else begin
            mem_we        = 1'b1;
            fill_cmd.inc  = 1'b1;
            res_d.success = 1'b1;
          end
        end else if (req_q.mode == wtw_pkg::MODE_CHECK) begin
          if (!day_ok) begin
            res_d.fault = wtw_pkg::FAULT_DAY;
          end else if (!wtw_pkg::time_ok(req_q.query_hour, req_q.query_minute)) begin
            res_d.fault = wtw_pkg::FAULT_TIME;
          end else if (count != '0) begin
            // Start the walk at the first window of the day.
            done_d      = 1'b0;
            state_d     = wtw_pkg::ST_SCAN;
            rd_idx_addr = '0;
            rd_idx_d    = '0;
            mem_re      = 1'b1;
          end
        end
      end

      wtw_pkg::ST_SCAN: begin
        if (hit) begin
          done_d        = 1'b1;
          res_d.success = 1'b1;
          state_d       = wtw_pkg::ST_IDLE;
        end else if (next_idx >= count) begin
          done_d  = 1'b1;
          state_d = wtw_pkg::ST_IDLE;
        end else begin
          // Fetch the next window while this one is compared.
          rd_idx_addr = IdxW'(next_idx);
          rd_idx_d    = IdxW'(next_idx);
          mem_re      = 1'b1;
        end
      end

      default: begin
        state_d = wtw_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wtw_pkg::ST_IDLE;
      rd_idx_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      done_q   <= done_d;
    end
  end

  // Payload registers: held input word and result word.
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == wtw_pkg::ST_IDLE)) begin
      req_q <= req_i;
    end
    if (done_d) begin
      res_q <= res_d;
    end
  end

  assign busy_o = state_q != wtw_pkg::ST_IDLE;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== dv/wtw_answer_checker.sv =====
// Checker for the weekly time window table: predicts each answer word and compares it.
`timescale 1ns / 100ps

module wtw_answer_checker #(
  parameter int SLOTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  wtw_pkg::req_t req_i,
  input  logic          done_i,
  input  wtw_pkg::res_t res_i,
  output int            pending_o,
  output int            errors_o
);
  import wtw_pkg::*;

  // Shadow copy of the table, with windows kept as minute-of-day bounds.
  logic [10:0]  win_open  [Days][SLOTS];
  logic [10:0]  win_close [Days][SLOTS];
  int unsigned  day_fill  [Days];

  // Answers that the table still owes, oldest first.
  res_t due_answers [$];
  res_t want;

  function automatic logic clock_ok(logic [4:0] h, logic [5:0] m);
    return (h <= 5'd23) && (m <= 6'd59);
  endfunction

  function automatic logic [10:0] to_minutes(logic [4:0] h, logic [5:0] m);
    return 11'(h) * 11'd60 + 11'(m);
  endfunction

  // Apply one word to the shadow table and work out the answer it earns.
  task automatic predict_answer(input req_t w, output res_t r);
    logic [10:0] q;
    int          d;
    int          n;
    int          i;
    r.success = 1'b0;
    r.fault   = FAULT_NONE;
    d = int'(w.day);
    case (w.mode)
      MODE_CLEAR: begin
        for (i = 0; i < Days; i++) day_fill[i] = 0;
        r.success = 1'b1;
      end
      MODE_ADD: begin
        if (d >= Days) begin
          r.fault = FAULT_DAY;
        end else if (day_fill[d] >= SLOTS) begin
          r.fault = FAULT_FULL;
        end else if (!clock_ok(w.start_hour, w.start_minute) ||
                     !clock_ok(w.end_hour, w.end_minute) ||
                     to_minutes(w.start_hour, w.start_minute) >=
                     to_minutes(w.end_hour, w.end_minute)) begin
          r.fault = FAULT_TIME;
        end else begin
          win_open[d][day_fill[d]]  = to_minutes(w.start_hour, w.start_minute);
          win_close[d][day_fill[d]] = to_minutes(w.end_hour, w.end_minute);
          day_fill[d]++;
          r.success = 1'b1;
        end
      end
      MODE_CHECK: begin
        if (d >= Days) begin
          r.fault = FAULT_DAY;
        end else if (!clock_ok(w.query_hour, w.query_minute)) begin
          r.fault = FAULT_TIME;
        end else begin
          // Both window ends count as inside.
          q = to_minutes(w.query_hour, w.query_minute);
          n = (day_fill[d] > SLOTS) ? SLOTS : int'(day_fill[d]);
          for (i = 0; i < n; i++) begin
            if (win_open[d][i] <= q && q <= win_close[d][i]) r.success = 1'b1;
          end
        end
      end
      default: begin
        // The spare mode leaves the table alone and answers all zero.
      end
    endcase
  endtask

  // Watch both channels; the answer of an earlier word is handled first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Days; i++) day_fill[i] = 0;
      due_answers.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (done_i) begin
        if (due_answers.size() == 0) begin
          $display("%0t: answer word with none expected: success=%0b fault=%0d",
                   $time, res_i.success, res_i.fault);
          errors_o++;
        end else begin
          want = due_answers.pop_front();
          if (res_i.success !== want.success) begin
            $display("%0t: success mismatch, expected %0b, actual %0b",
                     $time, want.success, res_i.success);
            errors_o++;
          end
          if (res_i.fault !== want.fault) begin
            $display("%0t: fault mismatch, expected %0d, actual %0d",
                     $time, want.fault, res_i.fault);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_answer(req_i, want);
        due_answers.push_back(want);
      end
      pending_o = due_answers.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the weekly time window table testbench: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module testbench;
  import wtw_pkg::*;

  localparam int          TableSlots = 8;
  localparam int          CycleLimit = 200000;
  localparam int          PhaseWords = 230;
  localparam logic [1:0]  ModeSpare  = 2'd3;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  done_o;
  res_t  res_o;

  int    pending;
  int    errors;
  int    cycle_count = 0;
  int    sender_idle = 0;

  weekly_time_window_table #(.SLOTS(TableSlots)) uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  wtw_answer_checker #(.SLOTS(TableSlots)) u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_i    (busy_o),
    .req_i     (req_i),
    .done_i    (done_o),
    .res_i     (res_o),
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** weekly_time_window_table: FAILED **");
      $finish;
    end
  end

  function automatic req_t make_word(logic [1:0] mode, logic [2:0] day,
                                     logic [4:0] sh, logic [5:0] sm,
                                     logic [4:0] eh, logic [5:0] em,
                                     logic [4:0] qh, logic [5:0] qm);
    req_t w;
    w = '{mode, day, sh, sm, eh, em, qh, qm};
    return w;
  endfunction

  // Minutes lean toward quarter hours so that queries often hit window edges.
  function automatic logic [5:0] rand_minute();
    logic [5:0] quarters [5];
    quarters = '{6'd0, 6'd15, 6'd30, 6'd45, 6'd59};
    if ($urandom_range(0, 1) == 0) return quarters[$urandom_range(0, 4)];
    return 6'($urandom_range(0, 59));
  endfunction

  // Mostly well-formed words on a few busy days; the rest is raw noise.
  function automatic req_t rand_word();
    req_t        w;
    logic [63:0] bits;
    int          pick;
    int          top_hour;
    bits = {$urandom, $urandom};
    w    = bits[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 1)       w.mode = MODE_CLEAR;
    else if (pick < 3)  w.mode = ModeSpare;
    else if (pick < 48) w.mode = MODE_ADD;
    else                w.mode = MODE_CHECK;
    if ($urandom_range(0, 99) < 85) begin
      pick = $urandom_range(0, 99);
      if (pick < 6)       w.day = 3'd7;
      else if (pick < 46) w.day = 3'($urandom_range(0, 1));
      else                w.day = 3'($urandom_range(0, 6));
      w.start_hour   = 5'($urandom_range(0, 22));
      top_hour       = (int'(w.start_hour) + 3 > 23) ? 23 : int'(w.start_hour) + 3;
      w.end_hour     = 5'($urandom_range(int'(w.start_hour), top_hour));
      w.start_minute = rand_minute();
      w.end_minute   = rand_minute();
      w.query_hour   = 5'($urandom_range(0, 23));
      w.query_minute = rand_minute();
    end
    return w;
  endfunction

  // Offer one word, with random gaps first, and return at the falling edge after it is taken.
  task automatic send_word(input req_t w);
    logic [63:0] junk;
    while ($urandom_range(0, 99) < sender_idle) begin
      junk    = {$urandom, $urandom};
      start_i <= 1'b0;
      req_i   <= junk[$bits(req_t)-1:0];
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold the sender off until every answer owed has come back.
  task automatic drain_answers();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int k;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words: faults of every kind, inclusive ends and a full day.
    send_word(make_word(MODE_CLEAR, 3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_CHECK, 3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 5'd12, 6'd0));
    send_word(make_word(MODE_ADD, 3'd7, 5'd8, 6'd0, 5'd9, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_CHECK, 3'd7, 5'd0, 6'd0, 5'd0, 6'd0, 5'd8, 6'd0));
    send_word(make_word(MODE_ADD, 3'd0, 5'd24, 6'd0, 5'd23, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_ADD, 3'd0, 5'd1, 6'd60, 5'd2, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_ADD, 3'd0, 5'd1, 6'd0, 5'd31, 6'd63, 5'd0, 6'd0));
    send_word(make_word(MODE_ADD, 3'd0, 5'd10, 6'd0, 5'd10, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_ADD, 3'd0, 5'd11, 6'd0, 5'd10, 6'd59, 5'd0, 6'd0));
    send_word(make_word(MODE_ADD, 3'd0, 5'd0, 6'd0, 5'd23, 6'd59, 5'd0, 6'd0));
    send_word(make_word(MODE_CHECK, 3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 5'd23, 6'd59));
    send_word(make_word(MODE_CHECK, 3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 5'd31, 6'd0));
    send_word(make_word(MODE_CHECK, 3'd0, 5'd0, 6'd0, 5'd0, 6'd0, 5'd12, 6'd63));
    send_word(make_word(ModeSpare, 3'd0, 5'd31, 6'd63, 5'd31, 6'd63, 5'd31, 6'd63));
    for (k = 0; k < TableSlots; k++) begin
      send_word(make_word(MODE_ADD, 3'd6, 5'(3 * k), 6'd0, 5'(3 * k), 6'd30, 5'd0, 6'd0));
    end
    // A full day wins over a bad time.
    send_word(make_word(MODE_ADD, 3'd6, 5'd25, 6'd63, 5'd0, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_CHECK, 3'd6, 5'd0, 6'd0, 5'd0, 6'd0, 5'd21, 6'd30));
    send_word(make_word(MODE_CHECK, 3'd6, 5'd0, 6'd0, 5'd0, 6'd0, 5'd0, 6'd0));
    send_word(make_word(MODE_CHECK, 3'd6, 5'd0, 6'd0, 5'd0, 6'd0, 5'd3, 6'd31));
    drain_answers();

    // Random words in three phases of sender pressure.
    sender_idle = 30;
    for (k = 0; k < PhaseWords; k++) send_word(rand_word());
    drain_answers();
    sender_idle = 88;
    for (k = 0; k < PhaseWords; k++) send_word(rand_word());
    drain_answers();
    sender_idle = 0;
    for (k = 0; k < PhaseWords; k++) send_word(rand_word());

    // Let the last answers come home, then give the verdict.
    drain_answers();
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("** weekly_time_window_table: PASSED **");
    end else begin
      $display("** weekly_time_window_table: FAILED **");
    end
    $finish;
  end

endmodule
